### rtl/mos_pkg.sv
// Shared types and constants for the median-of-set block.
package mos_pkg;

    localparam int MAX_ITEMS      = 16;
    localparam int VALUE_BITS     = 8;
    localparam int COUNT_BITS     = 5;
    localparam int MEDX2_BITS     = VALUE_BITS + 1;
    localparam int IDX_BITS       = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_BITS       = $clog2(MAX_ITEMS + 1);
    localparam int IN_TDATA_BITS  = ((VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS  = MEDX2_BITS + COUNT_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_DATA_BITS + 7) / 8) * 8;

    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
    localparam int QLVL_BITS      = QPTR_BITS + 1;

    typedef struct packed {
        logic                  last;
        logic [VALUE_BITS-1:0] value;
    } item_t;

    typedef struct packed {
        logic [QLVL_BITS-1:0] level;
        logic                 full;
    } qstat_t;

    typedef struct packed {
        logic [MEDX2_BITS-1:0] median_x2;
        logic [COUNT_BITS-1:0] count;
        logic                  overflow;
    } result_t;

endpackage

### rtl/mos_queue.sv
// Front end: accepts input items into a short queue ahead of the sorting row.
module mos_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  mos_pkg::item_t  push_item,
    input  logic            pop,
    output logic            item_valid,
    output mos_pkg::item_t  item,
    output mos_pkg::qstat_t status
);

    mos_pkg::item_t                  slot_reg [mos_pkg::QUEUE_DEPTH];
    logic [mos_pkg::QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [mos_pkg::QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [mos_pkg::QLVL_BITS-1:0]   level_reg, level_next;
    logic                            do_push;
    logic                            do_pop;

    assign status.level = level_reg;
    assign status.full  = (level_reg == mos_pkg::QLVL_BITS'(mos_pkg::QUEUE_DEPTH));
    assign item_valid   = (level_reg != '0);
    assign item         = slot_reg[rd_ptr_reg];

    assign do_push = push && !status.full;
    assign do_pop  = pop && item_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + mos_pkg::QPTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + mos_pkg::QPTR_BITS'(1) : rd_ptr_reg;
        level_next  = level_reg;
        if (do_push && !do_pop) begin
            level_next = level_reg + mos_pkg::QLVL_BITS'(1);
        end else if (do_pop && !do_push) begin
            level_next = level_reg - mos_pkg::QLVL_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/mos_sort_row.sv
// Back end: sorted-insertion row of cells, median pick and result register.
module mos_sort_row (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             item_valid,
    input  mos_pkg::item_t   item,
    output logic             item_take,
    output logic             res_valid,
    output mos_pkg::result_t res,
    input  logic             res_ready
);

    logic [mos_pkg::VALUE_BITS-1:0] cell_reg  [mos_pkg::MAX_ITEMS];
    logic [mos_pkg::VALUE_BITS-1:0] cell_next [mos_pkg::MAX_ITEMS];
    logic [mos_pkg::CNT_BITS-1:0]   count_reg, count_next;
    logic                           dropped_reg, dropped_next;
    logic                           res_valid_reg, res_valid_next;
    mos_pkg::result_t               res_reg, res_next;

    logic [mos_pkg::MAX_ITEMS-1:0]  gt;
    logic [mos_pkg::MAX_ITEMS-1:0]  occupied;
    logic                           has_room;
    logic [mos_pkg::CNT_BITS-1:0]   count_ins;
    logic                           dropped_ins;
    logic [mos_pkg::IDX_BITS-1:0]   hi_idx;
    logic [mos_pkg::IDX_BITS-1:0]   lo_idx;
    logic [mos_pkg::VALUE_BITS-1:0] med_lo;
    logic [mos_pkg::VALUE_BITS-1:0] med_hi;
    logic [mos_pkg::MEDX2_BITS-1:0] med_sum;
    logic                           closing;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // a closing item needs the result register free
    assign item_take = item_valid && (!item.last || !res_valid_reg || res_ready);
    assign closing   = item_take && item.last;
    assign has_room  = (count_reg < mos_pkg::CNT_BITS'(mos_pkg::MAX_ITEMS));

    always_comb begin
        for (int i = 0; i < mos_pkg::MAX_ITEMS; i++) begin
            gt[i]       = (cell_reg[i] > item.value);
            occupied[i] = (mos_pkg::CNT_BITS'(i) < count_reg);
        end
        // keep cells below the slot, shift those above it, drop the value in between
        for (int i = 0; i < mos_pkg::MAX_ITEMS; i++) begin
            if (occupied[i] && !gt[i]) begin
                cell_next[i] = cell_reg[i];
            end else if (i > 0 && occupied[(i > 0) ? i - 1 : 0] && gt[(i > 0) ? i - 1 : 0]) begin
                cell_next[i] = cell_reg[(i > 0) ? i - 1 : 0];
            end else begin
                cell_next[i] = item.value;
            end
        end
    end

    always_comb begin
        count_ins   = has_room ? count_reg + mos_pkg::CNT_BITS'(1) : count_reg;
        dropped_ins = dropped_reg || !has_room;
        hi_idx      = mos_pkg::IDX_BITS'(count_ins >> 1);
        lo_idx      = count_ins[0] ? hi_idx : hi_idx - mos_pkg::IDX_BITS'(1);
        // a full row keeps its cells, the dropped value never enters
        med_lo      = has_room ? cell_next[lo_idx] : cell_reg[lo_idx];
        med_hi      = has_room ? cell_next[hi_idx] : cell_reg[hi_idx];
        if (count_ins == '0) begin
            med_sum = '0;
        end else begin
            med_sum = {1'b0, med_lo} + {1'b0, med_hi};
        end
    end

    always_comb begin
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        if (item_take) begin
            if (item.last) begin
                count_next   = '0;
                dropped_next = 1'b0;
            end else begin
                count_next   = count_ins;
                dropped_next = dropped_ins;
            end
        end
        if (closing) begin
            res_valid_next     = 1'b1;
            res_next.median_x2 = med_sum;
            res_next.count     = mos_pkg::COUNT_BITS'(count_ins);
            res_next.overflow  = dropped_ins;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        if (item_take && has_room) begin
            for (int i = 0; i < mos_pkg::MAX_ITEMS; i++) begin
                cell_reg[i] <= cell_next[i];
            end
        end
    end

endmodule

### rtl/median_of_small_set.sv
// Top level of the median-of-set block: input queue feeding the sorting row.
//
// Usage: values stream in on the s_axis channel, one per item; tlast marks
// the item that closes the set (it belongs to the set). For each closing
// item one result leaves on m_axis: twice the median of the kept values
// (one implied fractional bit), the number of values kept, and in tuser a
// flag telling that values beyond the store's capacity were dropped.
// Throughput: one item per cycle sustained while no closing item waits on a
// pending result; the sorting row computes each insertion into its row of
// cells combinationally and registers it. Path: an item enters the
// four-entry input queue at its accepting edge, the row takes it from the
// queue head and registers the result, which drives m_axis_tvalid.
// Stalls: when m_axis_tready is low and a result waits, the row still takes
// items that do not close a set; a closing item waits in the queue, and
// s_axis_tready drops once the queue fills.
// Reset: aresetn (synchronous, active low) empties the queue, clears the
// set count and the dropped flag and withdraws any pending result.
module median_of_small_set (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [mos_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,  // value
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [mos_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,  // median_x2, count
    output logic                               m_axis_tuser   // overflow
);

    mos_pkg::item_t   in_item;
    mos_pkg::item_t   q_item;
    mos_pkg::qstat_t  q_status;
    logic             q_valid;
    logic             q_take;
    mos_pkg::result_t res;

    assign in_item.value = s_axis_tdata[mos_pkg::VALUE_BITS-1:0];
    assign in_item.last  = s_axis_tlast;
    assign s_axis_tready = !q_status.full;

    mos_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_axis_tvalid),
        .push_item  (in_item),
        .pop        (q_take),
        .item_valid (q_valid),
        .item       (q_item),
        .status     (q_status)
    );

    mos_sort_row u_sort_row (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (q_valid),
        .item       (q_item),
        .item_take  (q_take),
        .res_valid  (m_axis_tvalid),
        .res        (res),
        .res_ready  (m_axis_tready)
    );

    assign m_axis_tdata = mos_pkg::OUT_TDATA_BITS'({res.count, res.median_x2});
    assign m_axis_tuser = res.overflow;

    a_queue_level : assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.level <= mos_pkg::QLVL_BITS'(mos_pkg::QUEUE_DEPTH))
        else $error("input queue level beyond its depth");

    a_ovf_full : assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |->
        res.count == mos_pkg::COUNT_BITS'(mos_pkg::MAX_ITEMS))
        else $error("overflow reported with a store that was not full");

    a_nonempty : assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> res.count != '0)
        else $error("result for an empty set");

    a_take_valid : assert property (@(posedge aclk) disable iff (!aresetn)
        q_take |-> q_valid)
        else $error("sorting row took an item from an empty queue");

endmodule
